// ===== hdl/pctd_pkg.sv =====
// ----------------------------------------------------------------------------
// pctd_pkg
// Shared types and constants for the PID controller with tick-based
// derivative: sequencer states, configuration register indexes and result width.
// ----------------------------------------------------------------------------
package pctd_pkg;

  // Configuration register index port width and register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 2'd2;

  // Result field width
  localparam int DRIVE_W = 32;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_I,
    ST_ADD_I,
    ST_MUL_P,
    ST_ADD_P,
    ST_DIV,
    ST_MUL_D,
    ST_ADD_D,
    ST_OUT
  } pctd_state_t;

endpackage

// ===== hdl/pid_controller_tick_derivative.sv =====
// ----------------------------------------------------------------------------
// pid_controller_tick_derivative
// PID controller per sample: error, saturating integral, derivative over the
// ticks elapsed, and a saturated drive, computed by one shared multiplier,
// one shared adder and a bit-serial divider under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+---------------------------------
//  in_     | input     | tvalid / tready  | tdata: measured, setpoint, tick_now
//  out_    | output    | tvalid / tready  | tdata: drive; tuser: saturated
//  cfg_    | input     | we (no wait)     | index, data: gain register write
//
//  Each item runs through its steps in order: multiply and add for the
//  integral, multiply and add for the proportional term, the bit-serial
//  divider's DATA_WIDTH + 1 steps, multiply and add for the derivative,
//  and the output step; the three multiplies and three adds use the shared units.
//  in_tready is high only while the sequencer is idle. A finished result
//  sits in the output register, so the next item is accepted while it waits;
//  the sequencer holds in its final step only if the register is still full.
//  rst_n is synchronous, active low; it restores the gains and clears the
//  integral, previous error and previous tick.
//
module pid_controller_tick_derivative
  import pctd_pkg::*;
#(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8,
  parameter int TICK_WIDTH = 32,
  parameter int ACC_WIDTH  = 40
) (
  input  logic clk,
  input  logic rst_n,
  // measured [DATA_WIDTH-1:0], setpoint, tick_now, zero fill to whole bytes
  input  logic [((2*DATA_WIDTH+TICK_WIDTH+7)/8)*8-1:0] in_tdata,
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  // drive [31:0]
  output logic [DRIVE_W-1:0]                           out_tdata,
  // saturated [0]
  output logic                                         out_tuser,
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  input  logic                                         cfg_we,
  input  logic [CFG_IDX_W-1:0]                         cfg_index,
  input  logic [DATA_WIDTH-1:0]                        cfg_data
);

  // Widths: error, error change, dividend magnitude, product, datapath
  localparam int EW = DATA_WIDTH + 1;
  localparam int DFW = DATA_WIDTH + 2;
  localparam int NW = DATA_WIDTH + 1;
  localparam int PW = 2 * DATA_WIDTH + 2;
  localparam int SW = (2 * DATA_WIDTH + 3 > 66) ? 2 * DATA_WIDTH + 3 : 66;
  localparam int CW = $clog2(NW + 1);

  // Clip bounds, sign-extended to the datapath width
  localparam logic signed [SW-1:0] MAX64 = {{(SW-63){1'b0}}, {63{1'b1}}};
  localparam logic signed [SW-1:0] MIN64 = {{(SW-63){1'b1}}, {63{1'b0}}};
  localparam logic signed [SW-1:0] MAXACC =
    {{(SW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] MINACC =
    {{(SW-ACC_WIDTH+1){1'b1}}, {(ACC_WIDTH-1){1'b0}}};
  localparam logic signed [SW-1:0] MAXDRV =
    {{(SW-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}};
  localparam logic signed [SW-1:0] MINDRV =
    {{(SW-DRIVE_W+1){1'b1}}, {(DRIVE_W-1){1'b0}}};

  function automatic logic signed [SW-1:0] clip(input logic signed [SW-1:0] x,
                                                input logic signed [SW-1:0] lo,
                                                input logic signed [SW-1:0] hi);
    if (x > hi) begin
      return hi;
    end else if (x < lo) begin
      return lo;
    end
    return x;
  endfunction

  function automatic logic beyond(input logic signed [SW-1:0] x,
                                  input logic signed [SW-1:0] lo,
                                  input logic signed [SW-1:0] hi);
    return (x > hi) || (x < lo);
  endfunction

  // Input fields
  logic signed [DATA_WIDTH-1:0] in_measured;
  logic signed [DATA_WIDTH-1:0] in_setpoint;
  logic        [TICK_WIDTH-1:0] in_tick_now;

  assign in_measured = in_tdata[DATA_WIDTH-1:0];
  assign in_setpoint = in_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
  assign in_tick_now = in_tdata[2*DATA_WIDTH+TICK_WIDTH-1:2*DATA_WIDTH];

  // Registers
  pctd_state_t                  state_r, state_nxt;
  logic signed [DATA_WIDTH-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic signed [ACC_WIDTH-1:0]  integ_r, integ_nxt;
  logic signed [EW-1:0]         prev_err_r, prev_err_nxt;
  logic        [TICK_WIDTH-1:0] prev_tick_r, prev_tick_nxt;
  logic signed [EW-1:0]         err_r, err_nxt;
  logic                         neg_r, neg_nxt;
  logic        [TICK_WIDTH-1:0] div_r, div_nxt;
  logic        [TICK_WIDTH-1:0] rem_r, rem_nxt;
  logic        [NW-1:0]         quo_r, quo_nxt;
  logic        [CW-1:0]         cnt_r, cnt_nxt;
  logic signed [PW-1:0]         prod_r, prod_nxt;
  logic signed [SW-1:0]         sum_r, sum_nxt;
  logic                         sat_r, sat_nxt;
  logic        [DRIVE_W-1:0]    drive_r, drive_nxt;
  logic                         osat_r, osat_nxt;
  logic                         ovalid_r, ovalid_nxt;

  // Datapath signals
  logic                         in_acc;
  logic                         out_free;
  logic signed [EW-1:0]         err_in;
  logic signed [DFW-1:0]        diff_in;
  logic        [DFW-1:0]        diff_mag;
  logic        [TICK_WIDTH-1:0] elapsed;
  logic signed [DFW-1:0]        deriv;
  logic signed [DATA_WIDTH-1:0] mul_a;
  logic signed [DFW-1:0]        mul_b;
  logic signed [PW-1:0]         mul_p;
  logic signed [SW-1:0]         prod_ext;
  logic signed [SW-1:0]         prod_clip;
  logic signed [SW-1:0]         add_a;
  logic signed [SW-1:0]         add_s;
  logic signed [SW-1:0]         add_clip;
  logic        [TICK_WIDTH:0]   trial;
  logic        [TICK_WIDTH:0]   trial_sub;
  logic signed [SW-1:0]         shifted;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !ovalid_r || out_tready;

  // Front end: error, error change and elapsed ticks
  assign err_in   = EW'(in_setpoint) - EW'(in_measured);
  assign diff_in  = DFW'(err_in) - DFW'(prev_err_r);
  assign diff_mag = diff_in[DFW-1] ? DFW'(-diff_in) : DFW'(diff_in);
  assign elapsed  = (in_tick_now == prev_tick_r) ? TICK_WIDTH'(1)
                                                  : in_tick_now - prev_tick_r;

  // Signed quotient from the divider
  assign deriv = neg_r ? -DFW'({1'b0, quo_r}) : DFW'({1'b0, quo_r});

  // Shared multiplier operand select
  always_comb begin
    case (state_r)
      ST_MUL_I: mul_a = gain_i_r;
      ST_MUL_D: mul_a = gain_d_r;
      default:  mul_a = gain_p_r;
    endcase
    mul_b = (state_r == ST_MUL_D) ? deriv : DFW'(err_r);
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // Shared adder: clipped product plus integral or running sum
  assign prod_ext  = SW'(prod_r);
  assign prod_clip = clip(prod_ext, MIN64, MAX64);
  assign add_a     = (state_r == ST_ADD_D) ? sum_r : SW'(integ_r);
  assign add_s     = add_a + prod_clip;
  assign add_clip  = clip(add_s, MIN64, MAX64);

  // Divider step: shift in the next dividend bit, subtract if it fits
  assign trial     = {rem_r, quo_r[NW-1]};
  assign trial_sub = trial - {1'b0, div_r};

  // Scale the sum back and clip to the drive range
  assign shifted = sum_r >>> FRAC_BITS;

  // Sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    integ_nxt     = integ_r;
    prev_err_nxt  = prev_err_r;
    prev_tick_nxt = prev_tick_r;
    err_nxt       = err_r;
    neg_nxt       = neg_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    sum_nxt       = sum_r;
    sat_nxt       = sat_r;
    drive_nxt     = drive_r;
    osat_nxt      = osat_r;
    ovalid_nxt    = ovalid_r;

    // Drop the result once taken
    if (ovalid_r && out_tready) begin
      ovalid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          err_nxt       = err_in;
          neg_nxt       = diff_in[DFW-1];
          quo_nxt       = diff_mag[NW-1:0];
          div_nxt       = elapsed;
          rem_nxt       = '0;
          cnt_nxt       = '0;
          sat_nxt       = 1'b0;
          prev_err_nxt  = err_in;
          prev_tick_nxt = in_tick_now;
          state_nxt     = ST_MUL_I;
        end
      end
      ST_MUL_I: begin
        prod_nxt  = mul_p;
        state_nxt = ST_ADD_I;
      end
      ST_ADD_I: begin
        integ_nxt = ACC_WIDTH'(clip(add_clip, MINACC, MAXACC));
        sat_nxt   = sat_r || beyond(prod_ext, MIN64, MAX64) ||
                    beyond(add_s, MIN64, MAX64) || beyond(add_clip, MINACC, MAXACC);
        state_nxt = ST_MUL_P;
      end
      ST_MUL_P: begin
        prod_nxt  = mul_p;
        state_nxt = ST_ADD_P;
      end
      ST_ADD_P: begin
        sum_nxt   = add_clip;
        sat_nxt   = sat_r || beyond(prod_ext, MIN64, MAX64) || beyond(add_s, MIN64, MAX64);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // Advance one quotient bit
        if (!trial_sub[TICK_WIDTH]) begin
          rem_nxt = trial_sub[TICK_WIDTH-1:0];
          quo_nxt = {quo_r[NW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[TICK_WIDTH-1:0];
          quo_nxt = {quo_r[NW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(NW - 1)) begin
          state_nxt = ST_MUL_D;
        end
      end
      ST_MUL_D: begin
        prod_nxt  = mul_p;
        state_nxt = ST_ADD_D;
      end
      ST_ADD_D: begin
        sum_nxt   = add_clip;
        sat_nxt   = sat_r || beyond(prod_ext, MIN64, MAX64) || beyond(add_s, MIN64, MAX64);
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // Hold until the output register is free
        if (out_free) begin
          drive_nxt  = DRIVE_W'(clip(shifted, MINDRV, MAXDRV));
          osat_nxt   = sat_r || beyond(shifted, MINDRV, MAXDRV);
          ovalid_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state and item state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      integ_r     <= '0;
      prev_err_r  <= '0;
      prev_tick_r <= '0;
      ovalid_r    <= 1'b0;
      cnt_r       <= '0;
      sat_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      integ_r     <= integ_nxt;
      prev_err_r  <= prev_err_nxt;
      prev_tick_r <= prev_tick_nxt;
      ovalid_r    <= ovalid_nxt;
      cnt_r       <= cnt_nxt;
      sat_r       <= sat_nxt;
    end
  end

  // Gain registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= DATA_WIDTH'(256);
      gain_i_r <= '0;
      gain_d_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN_P: gain_p_r <= cfg_data;
        CFG_GAIN_I: gain_i_r <= cfg_data;
        CFG_GAIN_D: gain_d_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    err_r   <= err_nxt;
    neg_r   <= neg_nxt;
    div_r   <= div_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    prod_r  <= prod_nxt;
    sum_r   <= sum_nxt;
    drive_r <= drive_nxt;
    osat_r  <= osat_nxt;
  end

  assign out_tdata  = drive_r;
  assign out_tuser  = osat_r;
  assign out_tvalid = ovalid_r;

  // Checks
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> div_r != '0)
    else $error("divider running with zero divisor");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> cnt_r < CW'(NW))
    else $error("divider step count out of range");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_free) |=> (out_tvalid && state_r == ST_IDLE))
    else $error("result not loaded on final step");

  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_MUL_I && cnt_r == '0 && !sat_r))
    else $error("item accepted without starting the sequence");

endmodule
